FILE: hw/rtl/ecrs_pkg.sv
// ----------------------------------------------------------------------------
// ecrs_pkg
// Shared types, codes and constants of the three-channel echo ranging
// scheduler.
// ----------------------------------------------------------------------------
package ecrs_pkg;

    localparam int NUM_CH          = 3;
    localparam int CH_W            = 2;
    localparam int STAMP_W         = 16;
    localparam int MS_W            = 32;
    localparam int DIST_W          = 11;
    localparam int GUARD_W         = 16;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [GUARD_W-1:0] GUARD_RESET = 16'd60;
    localparam logic [DIST_W-1:0]  CLAMP_RESET = 11'd58;
    localparam logic [DIST_W-1:0]  RAW_RESET   = 11'd400;
    localparam logic [NUM_CH-1:0]  FRAME_ALL   = 3'h7;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD_MS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_CLAMP_CM = 2'd1;

    localparam logic [CH_W-1:0] CH_LEFT   = 2'd0;
    localparam logic [CH_W-1:0] CH_RIGHT  = 2'd1;
    localparam logic [CH_W-1:0] CH_CENTER = 2'd2;
    localparam logic [CH_W-1:0] CH_NONE   = 2'd3;

    // width / 58 = (width >> 1) / 29, done as a multiply by ceil(2^20 / 29)
    localparam int                 RECIP_SHIFT = 20;
    localparam logic [15:0]        RECIP_29    = 16'd36158;

    typedef enum logic [1:0] {
        OP_UPDATE  = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_IGNORE  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_WAIT_RISE = 2'd0,
        PH_WAIT_FALL = 2'd1,
        PH_DONE      = 2'd2
    } phase_t;

    typedef struct packed {
        op_t                op;
        logic [CH_W-1:0]    channel;
        logic [STAMP_W-1:0] capture_stamp;
        logic [MS_W-1:0]    now_ms;
    } cmd_t;

    function automatic logic [DIST_W-1:0] div58(input logic [STAMP_W-1:0] width);
        logic [30:0] prod;
        prod = 31'(width[STAMP_W-1:1]) * 31'(RECIP_29);
        return prod[RECIP_SHIFT+DIST_W-1:RECIP_SHIFT];
    endfunction

endpackage

FILE: hw/rtl/ecrs_if.sv
// ----------------------------------------------------------------------------
// ecrs_if
// Valid/ready channels of the echo ranging scheduler: input items, result
// items and configuration writes.
// ----------------------------------------------------------------------------
interface ecrs_in_if;
    import ecrs_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic [CH_W-1:0]    channel;
    logic [STAMP_W-1:0] capture_stamp;
    logic [MS_W-1:0]    now_ms;

    modport source (output valid, mode, channel, capture_stamp, now_ms, input ready);
    modport sink   (input valid, mode, channel, capture_stamp, now_ms, output ready);
endinterface

interface ecrs_out_if;
    import ecrs_pkg::*;

    logic              valid;
    logic              ready;
    logic              trigger_fire;
    logic [CH_W-1:0]   trigger_channel;
    logic              frame_done;
    logic [DIST_W-1:0] left_cm;
    logic [DIST_W-1:0] right_cm;
    logic [DIST_W-1:0] center_cm;

    modport source (output valid, trigger_fire, trigger_channel, frame_done,
                    left_cm, right_cm, center_cm, input ready);
    modport sink   (input valid, trigger_fire, trigger_channel, frame_done,
                    left_cm, right_cm, center_cm, output ready);
endinterface

interface ecrs_cfg_if;
    import ecrs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/ecrs_front.sv
// ----------------------------------------------------------------------------
// ecrs_front
// Takes input items and sorts them into update, capture and ignored
// commands for the command queue.
// ----------------------------------------------------------------------------
module ecrs_front (
    ecrs_in_if.sink         src,
    output logic            push_valid,
    input  logic            push_ready,
    output ecrs_pkg::cmd_t  push_data
);
    import ecrs_pkg::*;

    assign src.ready  = push_ready;
    assign push_valid = src.valid;

    always_comb
    begin
        push_data.channel       = src.channel;
        push_data.capture_stamp = src.capture_stamp;
        push_data.now_ms        = src.now_ms;
        if (!src.mode)
        begin
            push_data.op = OP_UPDATE;
        end
        else if (src.channel == CH_NONE)
        begin
            // capture on the unused channel code only yields a plain result
            push_data.op = OP_IGNORE;
        end
        else
        begin
            push_data.op = OP_CAPTURE;
        end
    end

endmodule

FILE: hw/rtl/ecrs_queue.sv
// ----------------------------------------------------------------------------
// ecrs_queue
// Short command queue between the front and the back, so either side can
// stall without holding the other.
// ----------------------------------------------------------------------------
module ecrs_queue #(
    parameter int DEPTH = ecrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  ecrs_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output ecrs_pkg::cmd_t pop_data
);
    import ecrs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/ecrs_back.sv
// ----------------------------------------------------------------------------
// ecrs_back
// Executes commands: echo capture with width and distance per channel,
// committed on update; frame collection, round-robin triggering, filtered output.
// Holds the configuration registers and the result register.
// ----------------------------------------------------------------------------
module ecrs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  ecrs_pkg::cmd_t cmd,
    ecrs_cfg_if.sink       cfg,
    ecrs_out_if.source     res
);
    import ecrs_pkg::*;

    phase_t             phase_reg   [NUM_CH];
    phase_t             phase_next  [NUM_CH];
    logic [NUM_CH-1:0]  armed_reg, armed_next;
    logic [STAMP_W-1:0] rise_reg    [NUM_CH];
    logic [STAMP_W-1:0] rise_next   [NUM_CH];
    logic [STAMP_W-1:0] pend_w_reg  [NUM_CH];
    logic [STAMP_W-1:0] pend_w_next [NUM_CH];
    logic [DIST_W-1:0]  pend_d_reg  [NUM_CH];
    logic [DIST_W-1:0]  pend_d_next [NUM_CH];
    logic [NUM_CH-1:0]  echo_nz_reg, echo_nz_next;
    logic [DIST_W-1:0]  raw_reg     [NUM_CH];
    logic [DIST_W-1:0]  raw_next    [NUM_CH];
    logic [DIST_W-1:0]  filt_reg    [NUM_CH];
    logic [DIST_W-1:0]  filt_next   [NUM_CH];
    logic [CH_W-1:0]    next_ch_reg, next_ch_next;
    logic [MS_W-1:0]    last_ms_reg, last_ms_next;
    logic [NUM_CH-1:0]  frame_reg, frame_next;
    logic [GUARD_W-1:0] guard_reg;
    logic [DIST_W-1:0]  clamp_reg;

    logic               out_valid_reg;
    logic               fire_reg, fire_next;
    logic [CH_W-1:0]    tch_reg, tch_next;
    logic               done_reg, done_next;
    logic [DIST_W-1:0]  dist_reg [NUM_CH];

    logic               go;

    assign cmd_ready = !out_valid_reg || res.ready;
    assign go        = cmd_valid && cmd_ready;
    assign cfg.ready = 1'b1;

    // channel state and result for the command at the head of the queue
    always_comb
    begin
        logic [STAMP_W-1:0] cap_width;
        logic [MS_W-1:0]    elapsed;
        logic [CH_W-1:0]    trig_ch;

        phase_next   = phase_reg;
        armed_next   = armed_reg;
        rise_next    = rise_reg;
        pend_w_next  = pend_w_reg;
        pend_d_next  = pend_d_reg;
        echo_nz_next = echo_nz_reg;
        raw_next     = raw_reg;
        filt_next    = filt_reg;
        next_ch_next = next_ch_reg;
        last_ms_next = last_ms_reg;
        frame_next   = frame_reg;
        fire_next    = 1'b0;
        tch_next     = CH_LEFT;
        done_next    = 1'b0;
        cap_width    = '0;
        elapsed      = cmd.now_ms - last_ms_reg;
        trig_ch      = (next_ch_reg == CH_NONE) ? CH_CENTER : next_ch_reg;

        if (go)
        begin
            unique case (cmd.op)
                OP_CAPTURE:
                begin
                    if (armed_reg[cmd.channel])
                    begin
                        if (phase_reg[cmd.channel] == PH_WAIT_RISE)
                        begin
                            rise_next[cmd.channel]  = cmd.capture_stamp;
                            phase_next[cmd.channel] = PH_WAIT_FALL;
                        end
                        else if (phase_reg[cmd.channel] == PH_WAIT_FALL)
                        begin
                            // width and distance prepared now, committed on update
                            cap_width                = cmd.capture_stamp - rise_reg[cmd.channel];
                            pend_w_next[cmd.channel] = cap_width;
                            pend_d_next[cmd.channel] = div58(cap_width);
                            phase_next[cmd.channel]  = PH_DONE;
                        end
                    end
                end
                OP_UPDATE:
                begin
                    for (int k = 0; k < NUM_CH; k++)
                    begin
                        if (phase_reg[k] == PH_DONE)
                        begin
                            echo_nz_next[k] = (pend_w_reg[k] != '0);
                            raw_next[k]     = pend_d_reg[k];
                            phase_next[k]   = PH_WAIT_RISE;
                            armed_next[k]   = 1'b0;
                        end
                    end
                    // stale echoes count as well
                    for (int k = 0; k < NUM_CH; k++)
                    begin
                        if (phase_next[k] == PH_WAIT_RISE && echo_nz_next[k])
                        begin
                            frame_next[k] = 1'b1;
                        end
                    end
                    if (elapsed >= MS_W'(guard_reg))
                    begin
                        phase_next[trig_ch] = PH_WAIT_RISE;
                        armed_next[trig_ch] = 1'b1;
                        fire_next           = 1'b1;
                        tch_next            = trig_ch;
                        next_ch_next        = (trig_ch == CH_CENTER) ? CH_LEFT
                                                                     : trig_ch + 1'b1;
                        last_ms_next        = cmd.now_ms;
                    end
                    if (frame_next == FRAME_ALL)
                    begin
                        filt_next[CH_LEFT]   = (raw_next[CH_LEFT] > clamp_reg)
                                               ? clamp_reg : raw_next[CH_LEFT];
                        filt_next[CH_RIGHT]  = (raw_next[CH_RIGHT] > clamp_reg)
                                               ? clamp_reg : raw_next[CH_RIGHT];
                        filt_next[CH_CENTER] = raw_next[CH_CENTER];
                        frame_next           = '0;
                        done_next            = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CH; k++)
            begin
                phase_reg[k] <= PH_WAIT_RISE;
                raw_reg[k]   <= RAW_RESET;
                filt_reg[k]  <= '0;
            end
            armed_reg     <= '0;
            echo_nz_reg   <= '0;
            next_ch_reg   <= CH_LEFT;
            last_ms_reg   <= '0;
            frame_reg     <= '0;
            guard_reg     <= GUARD_RESET;
            clamp_reg     <= CLAMP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            armed_reg   <= armed_next;
            echo_nz_reg <= echo_nz_next;
            raw_reg     <= raw_next;
            filt_reg    <= filt_next;
            next_ch_reg <= next_ch_next;
            last_ms_reg <= last_ms_next;
            frame_reg   <= frame_next;
            if (go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_GUARD_MS:      guard_reg <= cfg.data[GUARD_W-1:0];
                    CFG_SIDE_CLAMP_CM: clamp_reg <= cfg.data[DIST_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // stamps and result payload carry no reset
    always_ff @(posedge clk)
    begin
        rise_reg   <= rise_next;
        pend_w_reg <= pend_w_next;
        pend_d_reg <= pend_d_next;
        if (go)
        begin
            fire_reg <= fire_next;
            tch_reg  <= tch_next;
            done_reg <= done_next;
            dist_reg <= filt_next;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.trigger_fire    = fire_reg;
    assign res.trigger_channel = tch_reg;
    assign res.frame_done      = done_reg;
    assign res.left_cm         = dist_reg[CH_LEFT];
    assign res.right_cm        = dist_reg[CH_RIGHT];
    assign res.center_cm       = dist_reg[CH_CENTER];

endmodule

FILE: hw/rtl/three_channel_echo_ranging_scheduler.sv
// path: an accepted item goes through the command queue, then through the
// execute stage into the result register
// throughput: one item per cycle while the result register is not stalled
// reset: all channels idle and disarmed, raw distances 400, filtered 0,
// round robin at left, guard 60 ms, side clamp 58 cm; no clearing pass
// ----------------------------------------------------------------------------
// three_channel_echo_ranging_scheduler
// Round-robin scheduler for three ultrasonic rangers: echo capture, width to
// distance conversion, frame collection and distance output with side clamp.
// ----------------------------------------------------------------------------
module three_channel_echo_ranging_scheduler #(
    parameter int QUEUE_DEPTH = ecrs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ecrs_in_if.sink    src,
    ecrs_cfg_if.sink   cfg,
    ecrs_out_if.source res
);
    import ecrs_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_data;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_data;

    ecrs_front u_front (
        .src        (src),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    ecrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ecrs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_data),
        .cfg       (cfg),
        .res       (res)
    );

endmodule

FILE: hw/rtl/ecrs_checker.sv
// ----------------------------------------------------------------------------
// ecrs_checker
// Port-level checks of the echo ranging scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ecrs_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic                        trigger_fire,
    input logic [ecrs_pkg::CH_W-1:0]   trigger_channel,
    input logic                        frame_done,
    input logic [ecrs_pkg::DIST_W-1:0] left_cm,
    input logic [ecrs_pkg::DIST_W-1:0] right_cm,
    input logic [ecrs_pkg::DIST_W-1:0] center_cm
);
    import ecrs_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(trigger_fire)
            && $stable(trigger_channel) && $stable(frame_done)
            && $stable(left_cm) && $stable(right_cm) && $stable(center_cm))
        else $error("result changed while stalled");

    // no trigger means channel reads as left; a trigger never names the unused code 3
    a_trig_ch: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (trigger_fire ? (trigger_channel != CH_NONE)
                                    : (trigger_channel == CH_LEFT)))
        else $error("bad trigger channel");

    // distances stay within the ranger's range
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (left_cm <= 11'd1129) && (right_cm <= 11'd1129)
            && (center_cm <= 11'd1129))
        else $error("distance out of range");

    // no result straight out of reset
    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !res_valid)
        else $error("result valid after reset");

endmodule

bind three_channel_echo_ranging_scheduler ecrs_checker u_ecrs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .trigger_fire    (res.trigger_fire),
    .trigger_channel (res.trigger_channel),
    .frame_done      (res.frame_done),
    .left_cm         (res.left_cm),
    .right_cm        (res.right_cm),
    .center_cm       (res.center_cm)
);

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three-channel echo ranging scheduler. A
// scoreboard class keeps its own copy of the ranging state, predicts the
// result of every accepted item and compares each result field by field.
// Stimulus is a directed opening, then random ranging sequences under
// several register settings, with random gaps on both sides of the block.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ecrs_pkg::*;

    localparam logic MODE_UPDATE  = 1'b0;
    localparam logic MODE_CAPTURE = 1'b1;
    localparam int   US_PER_CM    = 58;
    localparam int   ITEMS_PER_SETTING = 195;

    typedef struct packed {
        logic              fire;
        logic [CH_W-1:0]   chan;
        logic              done;
        logic [DIST_W-1:0] left;
        logic [DIST_W-1:0] right;
        logic [DIST_W-1:0] center;
    } ranging_result_t;

    class ranging_scoreboard;
        logic [GUARD_W-1:0] guard;
        logic [DIST_W-1:0]  clamp;
        phase_t             phase [NUM_CH];
        bit                 armed [NUM_CH];
        logic [STAMP_W-1:0] rise [NUM_CH];
        logic [STAMP_W-1:0] fall [NUM_CH];
        logic [STAMP_W-1:0] width [NUM_CH];
        logic [DIST_W-1:0]  raw [NUM_CH];
        logic [DIST_W-1:0]  filt [NUM_CH];
        int                 next_ch;
        logic [MS_W-1:0]    last_trig;
        logic [NUM_CH-1:0]  frame;
        ranging_result_t    expected_q [$];
        int                 errors;
        int                 seen;

        function new();
            guard     = GUARD_RESET;
            clamp     = CLAMP_RESET;
            next_ch   = 0;
            last_trig = '0;
            frame     = '0;
            errors    = 0;
            seen      = 0;
            for (int k = 0; k < NUM_CH; k++)
            begin
                phase[k] = PH_WAIT_RISE;
                armed[k] = 1'b0;
                rise[k]  = '0;
                fall[k]  = '0;
                width[k] = '0;
                raw[k]   = RAW_RESET;
                filt[k]  = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_GUARD_MS)
                guard = value;
            else if (idx == CFG_SIDE_CLAMP_CM)
                clamp = value[DIST_W-1:0];
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_item(logic m, logic [CH_W-1:0] ch, logic [STAMP_W-1:0] stamp,
                                logic [MS_W-1:0] now);
            ranging_result_t r;
            int c;
            r = '0;
            c = int'(ch);
            if (m == MODE_CAPTURE)
            begin
                if (ch != CH_NONE && armed[c])
                begin
                    if (phase[c] == PH_WAIT_RISE)
                    begin
                        rise[c]  = stamp;
                        phase[c] = PH_WAIT_FALL;
                    end
                    else if (phase[c] == PH_WAIT_FALL)
                    begin
                        fall[c]  = stamp;
                        phase[c] = PH_DONE;
                    end
                end
            end
            else
            begin
                for (int k = 0; k < NUM_CH; k++)
                begin
                    if (phase[k] == PH_DONE)
                    begin
                        width[k] = fall[k] - rise[k];
                        raw[k]   = DIST_W'(int'(width[k]) / US_PER_CM);
                        phase[k] = PH_WAIT_RISE;
                        armed[k] = 1'b0;
                    end
                end
                // stale widths still count towards the frame
                for (int k = 0; k < NUM_CH; k++)
                    if (phase[k] == PH_WAIT_RISE && width[k] != 0)
                        frame[k] = 1'b1;
                if (MS_W'(now - last_trig) >= MS_W'(guard))
                begin
                    phase[next_ch] = PH_WAIT_RISE;
                    armed[next_ch] = 1'b1;
                    r.fire    = 1'b1;
                    r.chan    = CH_W'(next_ch);
                    next_ch   = (next_ch + 1) % NUM_CH;
                    last_trig = now;
                end
                if (frame == FRAME_ALL)
                begin
                    filt[0] = raw[0] > clamp ? clamp : raw[0];
                    filt[1] = raw[1] > clamp ? clamp : raw[1];
                    filt[2] = raw[2];
                    frame   = '0;
                    r.done  = 1'b1;
                end
            end
            r.left   = filt[0];
            r.right  = filt[1];
            r.center = filt[2];
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t: result %0d: %s", $realtime, seen, msg);
            errors++;
        endtask

        task cmp_field(string name, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
            if (got !== want)
                report($sformatf("%s is %0d, expected %0d", name, got, want));
        endtask

        task check_result(ranging_result_t got);
            ranging_result_t want;
            if (expected_q.size() == 0)
            begin
                report("result arrived with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            cmp_field("trigger_fire", DIST_W'(got.fire), DIST_W'(want.fire));
            cmp_field("trigger_channel", DIST_W'(got.chan), DIST_W'(want.chan));
            cmp_field("frame_done", DIST_W'(got.done), DIST_W'(want.done));
            cmp_field("left_cm", got.left, want.left);
            cmp_field("right_cm", got.right, want.right);
            cmp_field("center_cm", got.center, want.center);
            seen++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    ecrs_in_if  in_ch ();
    ecrs_cfg_if cfg_ch ();
    ecrs_out_if out_ch ();

    three_channel_echo_ranging_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (in_ch),
        .cfg   (cfg_ch),
        .res   (out_ch)
    );

    ranging_scoreboard sb;
    int in_calm;
    int out_calm;
    int out_wait;

    always #10 clk = ~clk;

    // per-item wait, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [STAMP_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return STAMP_W'($urandom_range(1, US_PER_CM - 1));
            2:       return '1;
            3, 4:    return STAMP_W'($urandom_range(US_PER_CM * 20, US_PER_CM * 80));
            default: return STAMP_W'($urandom_range(US_PER_CM, 65535));
        endcase
    endfunction

    always @(posedge clk)
    begin
        ranging_result_t got;
        if (rst_n === 1'b1)
        begin
            if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                sb.note_item(in_ch.mode, in_ch.channel, in_ch.capture_stamp, in_ch.now_ms);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got = '{out_ch.trigger_fire, out_ch.trigger_channel, out_ch.frame_done,
                        out_ch.left_cm, out_ch.right_cm, out_ch.center_cm};
                sb.check_result(got);
                out_wait = draw_wait(out_calm);
            end
        end
    end

    always @(negedge clk)
    begin
        if (out_wait > 0)
        begin
            out_ch.ready <= 1'b0;
            out_wait--;
        end
        else
            out_ch.ready <= 1'b1;
    end

    task automatic idle_src();
        int gap;
        gap = draw_wait(in_calm);
        @(negedge clk);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // called at a falling edge; returns at the edge that takes the item
    task automatic drive_src(logic m, logic [CH_W-1:0] ch, logic [STAMP_W-1:0] stamp,
                             logic [MS_W-1:0] now);
        in_ch.valid         <= 1'b1;
        in_ch.mode          <= m;
        in_ch.channel       <= ch;
        in_ch.capture_stamp <= stamp;
        in_ch.now_ms        <= now;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
    endtask

    task automatic issue(logic m, logic [CH_W-1:0] ch, logic [STAMP_W-1:0] stamp,
                         logic [MS_W-1:0] now);
        idle_src();
        drive_src(m, ch, stamp, now);
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_random(int n);
        int count;
        int sel;
        int c;
        int cand [$];
        logic m;
        logic [CH_W-1:0] ch;
        logic [STAMP_W-1:0] stamp;
        logic [MS_W-1:0] now;
        count = 0;
        while (count < n)
        begin
            idle_src();
            cand.delete();
            for (int k = 0; k < NUM_CH; k++)
                if (sb.armed[k] && sb.phase[k] != PH_DONE)
                    cand.push_back(k);
            sel   = $urandom_range(0, 99);
            m     = MODE_UPDATE;
            ch    = CH_W'($urandom_range(0, 3));
            stamp = STAMP_W'($urandom);
            now   = MS_W'($urandom);
            count++;
            if (sel < 45 && cand.size() != 0)
            begin
                // edge on a channel that is waiting for one
                c  = cand[$urandom_range(0, cand.size() - 1)];
                m  = MODE_CAPTURE;
                ch = CH_W'(c);
                if (sb.phase[c] == PH_WAIT_FALL)
                    stamp = sb.rise[c] + pick_width();
            end
            else if (sel < 72)
                now = sb.last_trig + MS_W'(sb.guard) + MS_W'($urandom_range(0, 40));
            else if (sel < 82 && sb.guard != 0)
                now = sb.last_trig + MS_W'($urandom_range(0, int'(sb.guard) - 1));
            else if (sel >= 88)
            begin
                m = MODE_CAPTURE;
                count--;
            end
            drive_src(m, ch, stamp, now);
        end
    endtask

    initial
    begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        sb                  = new();
        in_calm             = 0;
        out_calm            = 0;
        out_wait            = 0;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.mode          = MODE_UPDATE;
        in_ch.channel       = CH_LEFT;
        in_ch.capture_stamp = '0;
        in_ch.now_ms        = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_GUARD_MS;
        cfg_ch.data         = '0;
        out_ch.ready        = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed opening at reset settings
        issue(MODE_CAPTURE, CH_NONE, 16'hFFFF, 32'd0);
        issue(MODE_CAPTURE, CH_LEFT, 16'h1234, 32'd0);
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'd0);
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'd60);
        issue(MODE_CAPTURE, CH_LEFT, 16'hFFFF, 32'd0);
        // wraps round to the widest echo
        issue(MODE_CAPTURE, CH_LEFT, 16'hFFFE, 32'd0);
        issue(MODE_CAPTURE, CH_LEFT, 16'h0000, 32'd0);
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'd120);
        issue(MODE_CAPTURE, CH_RIGHT, 16'h0000, 32'd0);
        issue(MODE_CAPTURE, CH_RIGHT, 16'h1000, 32'd0);
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'd179);
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'd180);
        issue(MODE_CAPTURE, CH_CENTER, 16'd100, 32'd0);
        issue(MODE_CAPTURE, CH_CENTER, 16'd157, 32'd0);
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'hFFFF_FFFF);
        issue(MODE_CAPTURE, CH_CENTER, 16'd5, 32'd0);
        // timer wrap, and a frame made only of old echoes
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'd59);
        issue(MODE_CAPTURE, CH_RIGHT, 16'h1234, 32'd0);
        issue(MODE_CAPTURE, CH_RIGHT, 16'h1234, 32'd0);
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'd59);
        issue(MODE_CAPTURE, CH_LEFT, 16'h0000, 32'd0);
        issue(MODE_CAPTURE, CH_LEFT, 16'h8000, 32'd0);
        issue(MODE_UPDATE, CH_LEFT, 16'h0000, 32'd119);
        run_random(ITEMS_PER_SETTING);

        drain();
        write_reg(CFG_GUARD_MS, 16'd0);
        write_reg(CFG_SIDE_CLAMP_CM, 16'd0);
        run_random(ITEMS_PER_SETTING);

        drain();
        write_reg(CFG_GUARD_MS, 16'd1);
        write_reg(CFG_SIDE_CLAMP_CM, 16'd1129);
        run_random(ITEMS_PER_SETTING);

        // clamp above any reachable distance
        drain();
        write_reg(CFG_GUARD_MS, 16'hFFFF);
        write_reg(CFG_SIDE_CLAMP_CM, 16'd2047);
        run_random(ITEMS_PER_SETTING);

        drain();
        write_reg(CFG_GUARD_MS, 16'($urandom_range(1, 200)));
        write_reg(CFG_SIDE_CLAMP_CM, 16'($urandom_range(0, 1129)));
        run_random(ITEMS_PER_SETTING);

        drain();
        write_reg(CFG_GUARD_MS, GUARD_RESET);
        write_reg(CFG_SIDE_CLAMP_CM, 16'(CLAMP_RESET));
        run_random(ITEMS_PER_SETTING);

        drain();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/ecrs_pkg.sv
hw/rtl/ecrs_if.sv
hw/rtl/ecrs_front.sv
hw/rtl/ecrs_queue.sv
hw/rtl/ecrs_back.sv
hw/rtl/three_channel_echo_ranging_scheduler.sv
hw/rtl/ecrs_checker.sv
sim/tb_top.sv
